/* rtl/slis_pkg.sv */
// shared types and constants for the stereo line interleave split core
// used by slis_front, slis_queue, slis_back and the top level
package slis_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_PIXELS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER        = 2'd2;

    // register widths and reset values
    localparam int WIDTH_PIX_W = 11;
    localparam int CHAN_W      = 3;
    localparam int CFG_DATA_W  = 11;
    localparam logic [WIDTH_PIX_W-1:0] WIDTH_PIX_RST = 11'd640;
    localparam logic [CHAN_W-1:0]      CHAN_RST      = 3'd3;
    localparam int PROD_W = WIDTH_PIX_W + CHAN_W;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // per-item control flags from the front to the back
    typedef struct packed {
        logic is_src;     // source sample: writes the line buffers
        logic emit;       // produces an output item
        logic first_row;  // neighbor comes from row 1 or from the row itself
        logic left_raw;   // left view takes the raw row
        logic last;       // last item of the frame
    } op_ctrl_t;

endpackage

/* rtl/slis_front.sv */
// front end: config registers, row/column/drain counters and item classification
// depends on slis_pkg; feeds operations into slis_queue
module slis_front import slis_pkg::*; #(
    parameter int MAX_ROW_SAMPLES = 4096,
    parameter int SAMPLE_BITS     = 8,
    parameter int MAX_ROWS        = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_cmd,
    input  logic [SAMPLE_BITS-1:0]            s_sample,
    input  logic                              q_full,
    output logic                              push,
    output op_ctrl_t                          push_ctrl,
    output logic [$clog2(MAX_ROW_SAMPLES)-1:0] push_idx,
    output logic [SAMPLE_BITS-1:0]            push_sample,
    output logic [$clog2(MAX_ROWS)-1:0]       push_row
);

    localparam int IW = $clog2(MAX_ROW_SAMPLES);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int LW = $clog2(MAX_ROW_SAMPLES + 1);

    logic [WIDTH_PIX_W-1:0] width_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic                   order_reg;
    logic [LW-1:0]          row_len;
    logic [PROD_W-1:0]      prod;

    logic [IW-1:0] col_reg, col_next;
    logic [IW-1:0] drain_reg, drain_next;
    logic [RW-1:0] row_reg, row_next;
    logic          odd_reg, odd_next;

    logic          accept;
    logic          col_wrap;
    logic          drain_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_PIX_RST;
            chan_reg  <= CHAN_RST;
            order_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_WIDTH_PIXELS: width_reg <= cfg_wdata[WIDTH_PIX_W-1:0];
                    REG_CHANNELS:     chan_reg  <= cfg_wdata[CHAN_W-1:0];
                    REG_ORDER:        order_reg <= cfg_wdata[0];
                    default:          ;
                endcase
            end
        end
    end

    // row length follows the registers directly, so an item right after a write sees it
    assign prod = PROD_W'(width_reg) * PROD_W'(chan_reg);

    always_comb begin
        if (32'(prod) > MAX_ROW_SAMPLES) begin
            row_len = LW'(MAX_ROW_SAMPLES);
        end else if (prod == '0) begin
            row_len = LW'(1);
        end else begin
            row_len = LW'(prod);
        end
    end

    assign s_tready  = aresetn && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign col_wrap  = (LW'(col_reg) + LW'(1)) >= row_len;
    assign drain_end = (LW'(drain_reg) + LW'(1)) >= row_len;

    always_comb begin
        col_next    = col_reg;
        drain_next  = drain_reg;
        row_next    = row_reg;
        odd_next    = odd_reg;
        push        = 1'b0;
        push_ctrl   = '0;
        push_idx    = col_reg;
        push_sample = s_sample;
        push_row    = row_reg - RW'(1);
        push_ctrl.left_raw  = ((!odd_reg) == order_reg);
        push_ctrl.first_row = (row_reg == RW'(1));
        if (accept) begin
            if (s_cmd == CMD_SAMPLE) begin
                push             = 1'b1;
                push_ctrl.is_src = 1'b1;
                push_ctrl.emit   = (row_reg != '0);
                drain_next       = '0;
                if (col_wrap) begin
                    col_next = '0;
                    odd_next = !odd_reg;
                    if (row_reg < RW'(MAX_ROWS - 1)) begin
                        row_next = row_reg + RW'(1);
                    end
                end else begin
                    col_next = col_reg + IW'(1);
                end
            end else if (col_reg == '0 && row_reg != '0) begin
                // drain step: replay the final row against the row above it
                push           = 1'b1;
                push_ctrl.emit = 1'b1;
                push_idx       = drain_reg;
                if (drain_end) begin
                    push_ctrl.last = 1'b1;
                    drain_next     = '0;
                    col_next       = '0;
                    row_next       = '0;
                    odd_next       = 1'b0;
                end else begin
                    drain_next = drain_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            drain_reg <= '0;
            row_reg   <= '0;
            odd_reg   <= 1'b0;
        end else begin
            col_reg   <= col_next;
            drain_reg <= drain_next;
            row_reg   <= row_next;
            odd_reg   <= odd_next;
        end
    end

    a_drain_at_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg != '0 |-> (col_reg == '0 && row_reg != '0))
        else $error("drain in progress outside a row boundary");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_ctrl.last |=> (row_reg == '0 && drain_reg == '0 && !odd_reg))
        else $error("counters not cleared after last item of frame");

    a_source_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_cmd == CMD_SAMPLE |-> (push && push_ctrl.is_src))
        else $error("source item not queued");

endmodule

/* rtl/slis_queue.sv */
// short register queue that decouples the front end from the line buffer back end
// depends on slis_pkg for depth constants
module slis_queue import slis_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             q_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] q_data
);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || do_pop))
        else $error("push into a full queue");

endmodule

/* rtl/slis_back.sv */
// back end: two line buffers with read-before-write bypass, interpolation
// and the output register; depends on slis_pkg
module slis_back import slis_pkg::*; #(
    parameter int MAX_ROW_SAMPLES = 4096,
    parameter int SAMPLE_BITS     = 8,
    parameter int MAX_ROWS        = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    output logic                               pop,
    input  op_ctrl_t                           q_ctrl,
    input  logic [$clog2(MAX_ROW_SAMPLES)-1:0] q_idx,
    input  logic [SAMPLE_BITS-1:0]             q_sample,
    input  logic [$clog2(MAX_ROWS)-1:0]        q_row,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [SAMPLE_BITS-1:0]             m_left,
    output logic [SAMPLE_BITS-1:0]             m_right,
    output logic [$clog2(MAX_ROWS)-1:0]        m_row,
    output logic [$clog2(MAX_ROW_SAMPLES)-1:0] m_idx,
    output logic                               m_last
);

    localparam int IW = $clog2(MAX_ROW_SAMPLES);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0] newer_mem [MAX_ROW_SAMPLES];
    logic [SB-1:0] older_mem [MAX_ROW_SAMPLES];
    logic [SB-1:0] rd_newer_reg, rd_older_reg;

    // item whose buffer read has returned
    logic          x_valid_reg;
    op_ctrl_t      x_ctrl_reg;
    logic [IW-1:0] x_idx_reg;
    logic [SB-1:0] x_sample_reg;
    logic [RW-1:0] x_row_reg;
    logic          hit_reg;
    logic [SB-1:0] byp_newer_reg, byp_older_reg;

    logic          m_tvalid_reg;
    logic [SB-1:0] m_left_reg, m_right_reg;
    logic [RW-1:0] m_row_reg;
    logic [IW-1:0] m_idx_reg;
    logic          m_last_reg;

    logic          out_free;
    logic          adv;
    logic          wr_en;
    logic          load_out;
    logic [SB-1:0] eff_newer, eff_older;
    logic [SB-1:0] nb, other, interp;

    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = !x_valid_reg || !x_ctrl_reg.emit || out_free;
    assign pop      = adv && q_valid;
    assign wr_en    = adv && x_valid_reg && x_ctrl_reg.is_src;
    assign load_out = adv && x_valid_reg && x_ctrl_reg.emit;

    // the memory returns pre-write data when the item ahead writes the same entry
    assign eff_newer = hit_reg ? byp_newer_reg : rd_newer_reg;
    assign eff_older = hit_reg ? byp_older_reg : rd_older_reg;

    always_comb begin
        if (x_ctrl_reg.first_row) begin
            nb = x_ctrl_reg.is_src ? x_sample_reg : eff_newer;
        end else begin
            nb = eff_older;
        end
        other  = x_ctrl_reg.is_src ? x_sample_reg : nb;
        interp = (nb >> 1) + (other >> 1);
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_newer_reg <= newer_mem[q_idx];
            rd_older_reg <= older_mem[q_idx];
        end
        if (wr_en) begin
            newer_mem[x_idx_reg] <= x_sample_reg;
            older_mem[x_idx_reg] <= eff_newer;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_ctrl_reg    <= q_ctrl;
            x_idx_reg     <= q_idx;
            x_sample_reg  <= q_sample;
            x_row_reg     <= q_row;
            byp_newer_reg <= x_sample_reg;
            byp_older_reg <= eff_newer;
        end
        if (load_out) begin
            m_left_reg  <= x_ctrl_reg.left_raw ? eff_newer : interp;
            m_right_reg <= x_ctrl_reg.left_raw ? interp : eff_newer;
            m_row_reg   <= x_row_reg;
            m_idx_reg   <= x_idx_reg;
            m_last_reg  <= x_ctrl_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv) begin
                x_valid_reg <= pop;
                hit_reg     <= pop && wr_en && (q_idx == x_idx_reg);
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_left   = m_left_reg;
    assign m_right  = m_right_reg;
    assign m_row    = m_row_reg;
    assign m_idx    = m_idx_reg;
    assign m_last   = m_last_reg;

    a_hit_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg |-> x_valid_reg)
        else $error("bypass flagged without an item in the read stage");

endmodule

/* rtl/stereo_line_interleave_split_core.sv */
// top level of the stereo line interleave split core
// depends on slis_pkg, slis_front, slis_queue and slis_back
//
// Takes a line-interleaved stereo frame one channel sample per item and emits, one row
// behind the input, a left/right sample pair per position: one side is the raw row, the
// other the average of the rows above and below (each half truncated). The block takes
// one item every clock while its queue is not full. A source item is queued by the
// front end in the cycle it is accepted; the back end reads both line buffers (one
// read and one write port each) as it pulls the item from the queue into its read
// stage, then registers the result into the output register. A buffer entry written
// by the item just ahead is forwarded around the memory. After the last source row,
// send one drain item per sample of the row to flush it; the last one carries tlast
// and starts a new frame. The user must see that configuration is written only
// while idle; the block itself does not enforce this.
module stereo_line_interleave_split_core import slis_pkg::*; #(
    parameter int MAX_ROW_SAMPLES = 4096,
    parameter int SAMPLE_BITS     = 8,
    parameter int MAX_ROWS        = 4096
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           cfg_we,
    input  logic [CFG_ADDR_W-1:0]                          cfg_addr,
    input  logic [CFG_DATA_W-1:0]                          cfg_wdata,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]               s_tdata,
    // command
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // left_sample, right_sample, out_row, out_index
    output logic [((2*SAMPLE_BITS+$clog2(MAX_ROWS)+$clog2(MAX_ROW_SAMPLES)+7)/8)*8-1:0] m_tdata,
    // frame_last
    output logic                                           m_tlast
);

    localparam int IW = $clog2(MAX_ROW_SAMPLES);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int SB = SAMPLE_BITS;
    localparam int OUT_W = ((2*SB + RW + IW + 7) / 8) * 8;
    localparam int QW = $bits(op_ctrl_t) + IW + SB + RW;

    logic          push;
    op_ctrl_t      push_ctrl;
    logic [IW-1:0] push_idx;
    logic [SB-1:0] push_sample;
    logic [RW-1:0] push_row;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    logic [QW-1:0] q_data;
    op_ctrl_t      q_ctrl;
    logic [IW-1:0] q_idx;
    logic [SB-1:0] q_sample;
    logic [RW-1:0] q_row;
    logic [SB-1:0] m_left, m_right;
    logic [RW-1:0] m_row;
    logic [IW-1:0] m_idx;

    slis_front #(
        .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_ROWS        (MAX_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_cmd       (s_tuser),
        .s_sample    (s_tdata[SB-1:0]),
        .q_full      (q_full),
        .push        (push),
        .push_ctrl   (push_ctrl),
        .push_idx    (push_idx),
        .push_sample (push_sample),
        .push_row    (push_row)
    );

    slis_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctrl, push_idx, push_sample, push_row}),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    assign {q_ctrl, q_idx, q_sample, q_row} = q_data;

    slis_back #(
        .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_ROWS        (MAX_ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .pop      (pop),
        .q_ctrl   (q_ctrl),
        .q_idx    (q_idx),
        .q_sample (q_sample),
        .q_row    (q_row),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_left   (m_left),
        .m_right  (m_right),
        .m_row    (m_row),
        .m_idx    (m_idx),
        .m_last   (m_tlast)
    );

    assign m_tdata = OUT_W'({m_idx, m_row, m_right, m_left});

endmodule
